// ----- rtl/core/b64e_pkg.sv -----
`timescale 1ns / 1ps

package b64e_pkg;

  // Depth of the group queue between the front and back ends.
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [6:0] CHAR_UPPER_A = 7'h41;
  localparam logic [6:0] CHAR_LOWER_A = 7'h61;
  localparam logic [6:0] CHAR_ZERO    = 7'h30;
  localparam logic [6:0] CHAR_PLUS    = 7'h2B;
  localparam logic [6:0] CHAR_SLASH   = 7'h2F;
  localparam logic [6:0] CHAR_PAD     = 7'h3D;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } b64e_in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       end_of_text;
  } b64e_out_t;

  // One closed group: three bytes (zero filled), the number of real bytes
  // (1 to 3) and whether it ends the message.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } b64e_group_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] v);
    logic [6:0] c;
    begin
      priority if (v < 6'd26) begin
        c = CHAR_UPPER_A + 7'(v);
      end else if (v < 6'd52) begin
        c = CHAR_LOWER_A + 7'(v - 6'd26);
      end else if (v < 6'd62) begin
        c = CHAR_ZERO + 7'(v - 6'd52);
      end else if (v == 6'd62) begin
        c = CHAR_PLUS;
      end else begin
        c = CHAR_SLASH;
      end
      return c;
    end
  endfunction

endpackage

// ----- rtl/core/b64e_front.sv -----
`timescale 1ns / 1ps

module b64e_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  b64e_pkg::b64e_in_t    byte_data,
  output logic                  grp_valid,
  input  logic                  grp_ready,
  output b64e_pkg::b64e_group_t grp_data
);

  logic [1:0] held_count;
  logic [7:0] held0;
  logic [7:0] held1;
  logic [1:0] have;
  logic       closes;
  logic       accept;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  // A count of three never arises; it is read as a full pair of held bytes.
  assign have   = (held_count[1]) ? 2'd2 : held_count;
  assign closes = byte_data.final_byte || (have == 2'd2);

  assign byte_ready = grp_ready;
  assign accept     = byte_valid && byte_ready;
  assign grp_valid  = byte_valid && closes;

  always_comb begin
    b0 = (have != 2'd0) ? held0 : byte_data.data_byte;
    unique case (have)
      2'd0:    b1 = 8'd0;
      2'd1:    b1 = byte_data.data_byte;
      default: b1 = held1;
    endcase
    b2 = (have == 2'd2) ? byte_data.data_byte : 8'd0;
  end

  assign grp_data.bits   = {b0, b1, b2};
  assign grp_data.nbytes = have + 2'd1;
  assign grp_data.last   = byte_data.final_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (accept) begin
      held_count <= closes ? 2'd0 : (have + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !closes) begin
      if (have == 2'd0) begin
        held0 <= byte_data.data_byte;
      end else begin
        held1 <= byte_data.data_byte;
      end
    end
  end

endmodule

// ----- rtl/core/b64e_queue.sv -----
`timescale 1ns / 1ps

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  b64e_pkg::b64e_group_t push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output b64e_pkg::b64e_group_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64e_pkg::b64e_group_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/b64e_back.sv -----
`timescale 1ns / 1ps

module b64e_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  grp_valid,
  output logic                  grp_ready,
  input  b64e_pkg::b64e_group_t grp_data,
  output logic                  char_valid,
  input  logic                  char_ready,
  output b64e_pkg::b64e_out_t   char_data
);

  b64e_pkg::b64e_group_t cur;
  logic                  cur_valid;
  logic [1:0]            idx;
  logic                  load;
  logic                  done;
  logic [5:0]            sextet;
  b64e_pkg::b64e_out_t   next_char;

  // The output register takes a new character whenever it is empty or
  // being drained this cycle.
  assign load      = cur_valid && (!char_valid || char_ready);
  assign done      = load && (idx == 2'd3);
  assign grp_ready = !cur_valid || done;

  always_comb begin
    unique case (idx)
      2'd0:    sextet = cur.bits[23:18];
      2'd1:    sextet = cur.bits[17:12];
      2'd2:    sextet = cur.bits[11:6];
      default: sextet = cur.bits[5:0];
    endcase
    next_char.char_code   = (idx > cur.nbytes) ? b64e_pkg::CHAR_PAD
                                               : b64e_pkg::sextet_char(sextet);
    next_char.end_of_text = cur.last && (idx == 2'd3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      idx        <= 2'd0;
      char_valid <= 1'b0;
    end else begin
      if (grp_valid && grp_ready) begin
        cur_valid <= 1'b1;
        idx       <= 2'd0;
      end else if (done) begin
        cur_valid <= 1'b0;
        idx       <= 2'd0;
      end else if (load) begin
        idx <= idx + 2'd1;
      end
      if (load) begin
        char_valid <= 1'b1;
      end else if (char_ready) begin
        char_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      cur <= grp_data;
    end
    if (load) begin
      char_data <= next_char;
    end
  end

endmodule

// ----- rtl/core/base64_encoder_unit.sv -----
`timescale 1ns / 1ps
// Streaming base64 encoder with the standard alphabet.
// Byte channel (byte_valid/byte_ready/byte_data): one raw byte per request,
// with final_byte set on the last byte of a message.
// Char channel (char_valid/char_ready/char_data): one ASCII character per
// request; end_of_text marks the final character of the message.
// Every third byte, and every byte with final_byte set, closes a group and
// yields four characters; a short final group is zero filled and its unused
// places become '='.
// Once the request that closes a group is taken, its first character passes
// through the group queue, the group register and the output register.
// Throughput: one byte per cycle in, one character per cycle out while the
// receiver is ready; a steady stream is limited by the single output register
// of the back end. The front end keeps taking bytes while the group queue
// has room, so bursts up to QUEUE_DEPTH groups are absorbed.
// Reset clears the held bytes, the queue and the output register.
// When the receiver stalls, the current character holds, the queue fills and
// byte_ready drops once it is full.
module base64_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  b64e_pkg::b64e_in_t  byte_data,
  output logic                char_valid,
  input  logic                char_ready,
  output b64e_pkg::b64e_out_t char_data
);

  logic                  push_valid;
  logic                  push_ready;
  b64e_pkg::b64e_group_t push_data;
  logic                  pop_valid;
  logic                  pop_ready;
  b64e_pkg::b64e_group_t pop_data;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .grp_valid  (push_valid),
    .grp_ready  (push_ready),
    .grp_data   (push_data)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .grp_valid  (pop_valid),
    .grp_ready  (pop_ready),
    .grp_data   (pop_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int ITEMS        = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 24;

  // Base64 symbol table, first symbol in the top byte.
  localparam logic [8*64-1:0] SYMBOLS = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                         "abcdefghijklmnopqrstuvwxyz",
                                         "0123456789+/"};

  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;   // chars below hold the group this byte closes
    logic [31:0] chars;
  } stim_row_t;

  localparam int NUM_ROWS = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, "AA=="},
    '{8'hFF, 1'b1, 1'b1, "/w=="},
    '{8'h01, 1'b1, 1'b1, "AQ=="},
    '{8'h4D, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b1, 1'b1, "TWE="},
    '{8'h66, 1'b0, 1'b0, 32'h0},
    '{8'h6F, 1'b1, 1'b1, "Zm8="},
    '{8'h4D, 1'b0, 1'b0, 32'h0},
    '{8'h61, 1'b0, 1'b0, 32'h0},
    '{8'h6E, 1'b0, 1'b1, "TWFu"},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b0, 1'b1, "AAAA"},
    '{8'hFB, 1'b0, 1'b0, 32'h0},
    '{8'hEF, 1'b0, 1'b0, 32'h0},
    '{8'hBE, 1'b0, 1'b1, "++++"},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b0, 1'b0, 32'h0},
    '{8'hFF, 1'b1, 1'b1, "////"},
    '{8'hD7, 1'b0, 1'b0, 32'h0},
    '{8'h6D, 1'b0, 1'b0, 32'h0},
    '{8'hF8, 1'b0, 1'b0, 32'h0},
    '{8'h80, 1'b1, 1'b0, 32'h0}
  };

  typedef enum {RX_OPEN, RX_CHOPPY, RX_STARVED} rx_mode_e;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_ready;
  b64e_pkg::b64e_in_t  byte_data  = '0;
  logic                char_valid;
  logic                char_ready = 1'b0;
  b64e_pkg::b64e_out_t char_data;

  b64e_pkg::b64e_out_t expected_chars [$];
  logic [7:0] held_bytes [2] = '{8'h00, 8'h00};
  logic [1:0] held_count = 2'd0;

  int err_count     = 0;
  int chars_checked = 0;
  int bytes_sent    = 0;
  int messages_sent = 0;
  int burst_left    = 0;
  int cycle_count   = 0;
  int stall_left    = 0;
  rx_mode_e rx_mode = RX_OPEN;

  base64_encoder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_data  (char_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at cycle %0d: %s got 0x%02h expected 0x%02h",
             cycle_count, what, got, want);
    err_count++;
  endtask

  // Advances the group state by one byte; when the byte closes a group and
  // publish is set, the four characters are queued as expected.
  task automatic encode_byte(input b64e_pkg::b64e_in_t item, input bit publish);
    logic [1:0]          have;
    logic [7:0]          b0, b1, b2;
    logic [23:0]         group;
    logic [5:0]          sextet;
    b64e_pkg::b64e_out_t ch;
    have = (held_count > 2'd2) ? 2'd2 : held_count;
    if (!item.final_byte && have < 2'd2) begin
      held_bytes[have[0]] = item.data_byte;
      held_count = have + 2'd1;
    end else begin
      b0 = (have >= 2'd1) ? held_bytes[0] : item.data_byte;
      b1 = (have >= 2'd2) ? held_bytes[1] : ((have == 2'd1) ? item.data_byte : 8'h00);
      b2 = (have >= 2'd2) ? item.data_byte : 8'h00;
      group = {b0, b1, b2};
      if (publish) begin
        for (int k = 0; k < 4; k++) begin
          sextet = group[23 - 6*k -: 6];
          // Places past the real bytes of a short group become padding.
          if (k <= int'(have) + 1) begin
            ch.char_code = SYMBOLS[8*(63 - int'(sextet)) +: 7];
          end else begin
            ch.char_code = b64e_pkg::CHAR_PAD;
          end
          ch.end_of_text = item.final_byte && (k == 3);
          expected_chars.push_back(ch);
        end
      end
      held_bytes[0] = 8'h00;
      held_bytes[1] = 8'h00;
      held_count = 2'd0;
    end
  endtask

  // Presents one request and returns at the edge where it is taken.
  task automatic send_byte(input b64e_pkg::b64e_in_t item);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 10);
    end
    byte_valid <= 1'b1;
    byte_data  <= item;
    do @(posedge clk); while (!(byte_valid && byte_ready));
    burst_left--;
    bytes_sent++;
    if (item.final_byte) messages_sent++;
  endtask

  task automatic wait_for_drain();
    byte_valid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  task automatic check_char(input b64e_pkg::b64e_out_t got);
    b64e_pkg::b64e_out_t want;
    if (expected_chars.size() == 0) begin
      report_mismatch("char with nothing pending", got.char_code, 0);
    end else begin
      want = expected_chars.pop_front();
      chars_checked++;
      if (got.char_code !== want.char_code)
        report_mismatch("char_code", got.char_code, want.char_code);
      if (got.end_of_text !== want.end_of_text)
        report_mismatch("end_of_text", got.end_of_text, want.end_of_text);
    end
  endtask

  // Receiver: alternates between open, choppy and mostly stalled stretches.
  always @(posedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
    end else begin
      if (char_valid && char_ready) check_char(char_data);
      if (stall_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        stall_left = $urandom_range(16, 160);
      end
      stall_left--;
      case (rx_mode)
        RX_OPEN: begin
          char_ready <= 1'b1;
        end
        RX_CHOPPY: begin
          char_ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          char_ready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars still pending",
               cycle_count, expected_chars.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    b64e_pkg::b64e_in_t  item;
    b64e_pkg::b64e_out_t ch;
    int                  random_bytes;
    int                  msg_len;
    int                  pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_ROWS; i++) begin
      item.data_byte  = DIRECTED_ROWS[i].data;
      item.final_byte = DIRECTED_ROWS[i].fin;
      send_byte(item);
      if (DIRECTED_ROWS[i].typed) begin
        encode_byte(item, 1'b0);
        for (int k = 0; k < 4; k++) begin
          ch.char_code   = DIRECTED_ROWS[i].chars[8*(3 - k) +: 7];
          ch.end_of_text = DIRECTED_ROWS[i].fin && (k == 3);
          expected_chars.push_back(ch);
        end
      end else begin
        encode_byte(item, 1'b1);
      end
    end
    wait_for_drain();

    // Random messages, mostly short so that every padding case recurs.
    random_bytes = 0;
    while (random_bytes < ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) msg_len = $urandom_range(1, 6);
      else if (pick < 9) msg_len = $urandom_range(7, 20);
      else msg_len = $urandom_range(21, 48);
      for (int j = 0; j < msg_len; j++) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) item.data_byte = 8'h00;
        else if (pick == 1) item.data_byte = 8'hFF;
        else item.data_byte = 8'($urandom_range(0, 255));
        item.final_byte = (j == msg_len - 1);
        send_byte(item);
        encode_byte(item, 1'b1);
        random_bytes++;
      end
      if ($urandom_range(0, 15) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d messages of random length and content",
             bytes_sent, messages_sent);
    $display("checked %0d output characters under random sender gaps and receiver stalls",
             chars_checked);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/b64e_pkg.sv
rtl/core/b64e_front.sv
rtl/core/b64e_queue.sv
rtl/core/b64e_back.sv
rtl/core/base64_encoder_unit.sv
tb/testbench.sv
